// ===== hw/rtl/ysv_pkg.sv =====
// Shared types, constants and constant functions for the yield-stress viscosity block.
// Depends on nothing; every other file of the block imports it.
package ysv_pkg;

	localparam int VALUE_W             = 48;
	localparam int EXPO_N_W            = 16;
	localparam int EXPO_FRAC_BITS      = 12;
	localparam int RATE_FRAC_BITS      = 24;
	localparam int MANT_BITS           = 30;
	localparam int RATE_EXP_W          = 6;
	localparam int MAX_LOG_FRAC        = 24;
	localparam int POW_TABLE_ADDR_BITS_DEF = 8;
	localparam int QUEUE_DEPTH         = 4;
	localparam int QUEUE_PTR_W         = 2;
	localparam int QUEUE_CNT_W         = 3;
	localparam int CFG_INDEX_W         = 2;

	localparam logic [VALUE_W-1:0]  K_RESET   = '0;
	localparam logic [EXPO_N_W-1:0] N_RESET   = 16'd4096;
	localparam logic [VALUE_W-1:0]  TAU_RESET = '0;
	localparam logic [VALUE_W-1:0]  CAP_RESET = '1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CONSISTENCY = 2'd0,
		REG_EXPONENT    = 2'd1,
		REG_YIELD       = 2'd2,
		REG_CAP         = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  k;
		logic [EXPO_N_W-1:0] n;
		logic [VALUE_W-1:0]  tau0;
		logic [VALUE_W-1:0]  cap;
	} cfg_t;

	typedef struct packed {
		logic                  zero;
		logic [RATE_EXP_W-1:0] expo;
		logic [MANT_BITS:0]    mant;
		logic [VALUE_W-1:0]    rate;
	} front_item_t;

	typedef struct packed {
		logic               zero;
		logic [VALUE_W-1:0] rate;
	} tag_t;

	typedef struct packed {
		logic               over;
		logic [VALUE_W-1:0] kp;
		tag_t               tag;
	} power_res_t;

	typedef struct packed {
		logic [VALUE_W-1:0] viscosity;
		logic               capped;
	} result_t;

	// Floor square root, only ever evaluated on constants.
	function automatic logic [31:0] isqrt(input logic [63:0] v);
		logic [31:0] res;
		logic [31:0] t;
		res = '0;
		for (int b = 31; b >= 0; b--) begin
			t = res | (32'(1) << b);
			if (64'(t) * 64'(t) <= v) res = t;
		end
		return res;
	endfunction

	// Factors 2^(2^-(i+1)) in Q1.30, each the root of the one before.
	function automatic logic [MAX_LOG_FRAC-1:0][MANT_BITS:0] exp_table();
		logic [MAX_LOG_FRAC-1:0][MANT_BITS:0] tbl;
		logic [31:0] c;
		c = isqrt(64'(1) << 61);
		for (int i = 0; i < MAX_LOG_FRAC; i++) begin
			tbl[i] = c[MANT_BITS:0];
			c = isqrt(64'(c) << MANT_BITS);
		end
		return tbl;
	endfunction

endpackage

// ===== hw/rtl/ysv_if.sv =====
// Valid/ready channel interfaces for strain-rate input and viscosity result.
// Depends on ysv_pkg for the field widths.
interface ysv_rate_if;
	import ysv_pkg::*;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] strain_rate;
	modport source(output valid, output strain_rate, input ready);
	modport sink(input valid, input strain_rate, output ready);
endinterface

interface ysv_visc_if;
	import ysv_pkg::*;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] viscosity;
	logic               capped;
	modport source(output valid, output viscosity, output capped, input ready);
	modport sink(input valid, input viscosity, input capped, output ready);
endinterface

// ===== hw/rtl/ysv_front.sv =====
// Front end: takes strain-rate transfers and classifies them (zero rate, exponent, mantissa).
// Depends on ysv_pkg and ysv_rate_if.
module ysv_front (
	ysv_rate_if.sink            rate,
	input  logic                queue_full,
	output logic                push,
	output ysv_pkg::front_item_t item
);
	import ysv_pkg::*;

	logic [RATE_EXP_W-1:0]        msb;
	logic [VALUE_W+MANT_BITS-1:0] aligned;

	assign rate.ready = !queue_full;
	assign push       = rate.valid && !queue_full;

	always_comb begin
		msb = '0;
		for (int i = 0; i < VALUE_W; i++) begin
			if (rate.strain_rate[i]) msb = RATE_EXP_W'(i);
		end
	end

	// Leading one lands on bit 30, giving a Q1.30 mantissa.
	assign aligned   = {rate.strain_rate, {MANT_BITS{1'b0}}} >> msb;
	assign item.zero = (rate.strain_rate == '0);
	assign item.expo = msb;
	assign item.mant = aligned[MANT_BITS:0];
	assign item.rate = rate.strain_rate;

endmodule

// ===== hw/rtl/ysv_queue.sv =====
// Short queue that decouples the front end from the arithmetic back end.
// Depends on ysv_pkg.
module ysv_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ysv_pkg::front_item_t wr_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 rd_valid,
	output ysv_pkg::front_item_t rd_item
);
	import ysv_pkg::*;

	front_item_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]   wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]   rd_ptr_q;
	logic [QUEUE_CNT_W-1:0]   count_q;
	logic                     do_pop;

	assign full     = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== hw/rtl/ysv_power.sv =====
// Back end, first half: k * rate^n through a pipelined log2, a scaling multiply and exp2.
// Depends on ysv_pkg.
module ysv_power #(
	parameter int POW_TABLE_ADDR_BITS = ysv_pkg::POW_TABLE_ADDR_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  ysv_pkg::front_item_t in_item,
	input  ysv_pkg::cfg_t        cfg,
	output logic                 out_valid,
	output ysv_pkg::power_res_t  out_res
);
	import ysv_pkg::*;

	localparam int LF   = 2 * POW_TABLE_ADDR_BITS;
	localparam int LW   = RATE_EXP_W + LF;
	localparam int PW   = EXPO_N_W + LW;
	localparam int QW   = PW - EXPO_FRAC_BITS;
	localparam int SW   = 12;
	localparam int PRW  = VALUE_W + MANT_BITS + 1;
	localparam int HW   = VALUE_W / 2;
	localparam logic [MAX_LOG_FRAC-1:0][MANT_BITS:0] EXP_C = exp_table();

	// log2 chain: one squaring per stage
	logic               lg_v_s  [1:LF];
	logic [MANT_BITS:0] lg_x_s  [1:LF];
	logic [LF-1:0]      lg_f_s  [1:LF];
	logic [RATE_EXP_W-1:0] lg_p_s [1:LF];
	tag_t               lg_t_s  [1:LF];
	logic               lg_cv   [0:LF-1];
	logic [MANT_BITS:0] lg_cx   [0:LF-1];
	logic [LF-1:0]      lg_cf   [0:LF-1];
	logic [RATE_EXP_W-1:0] lg_cp [0:LF-1];
	tag_t               lg_ct   [0:LF-1];
	logic [MANT_BITS:0] lg_nx   [0:LF-1];
	logic [LF-1:0]      lg_nf   [0:LF-1];

	always_comb begin
		lg_cv[0] = in_valid;
		lg_cx[0] = in_item.mant;
		lg_cf[0] = '0;
		lg_cp[0] = in_item.expo;
		lg_ct[0] = '{zero: in_item.zero, rate: in_item.rate};
		for (int i = 1; i < LF; i++) begin
			lg_cv[i] = lg_v_s[i];
			lg_cx[i] = lg_x_s[i];
			lg_cf[i] = lg_f_s[i];
			lg_cp[i] = lg_p_s[i];
			lg_ct[i] = lg_t_s[i];
		end
	end

	always_comb begin
		logic [2*MANT_BITS+1:0] sq;
		for (int i = 0; i < LF; i++) begin
			sq = (2*MANT_BITS+2)'(lg_cx[i]) * (2*MANT_BITS+2)'(lg_cx[i]);
			lg_nx[i] = sq[2*MANT_BITS+1] ? sq[2*MANT_BITS+1:MANT_BITS+1]
			                             : sq[2*MANT_BITS:MANT_BITS];
			lg_nf[i] = {lg_cf[i][LF-2:0], sq[2*MANT_BITS+1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LF; i++) lg_v_s[i] <= 1'b0;
		end else if (adv) begin
			for (int i = 0; i < LF; i++) lg_v_s[i+1] <= lg_cv[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < LF; i++) begin
				lg_x_s[i+1] <= lg_nx[i];
				lg_f_s[i+1] <= lg_nf[i];
				lg_p_s[i+1] <= lg_cp[i];
				lg_t_s[i+1] <= lg_ct[i];
			end
		end
	end

	// n * log2(rate)
	logic          mul_v_s1;
	logic [PW-1:0] mul_p_s1;
	tag_t          mul_t_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mul_v_s1 <= 1'b0;
		else if (adv) mul_v_s1 <= lg_v_s[LF];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mul_p_s1 <= PW'(cfg.n) * PW'({lg_p_s[LF], lg_f_s[LF]});
			mul_t_s1 <= lg_t_s[LF];
		end
	end

	// Remove the rate's binary point and split into integer exponent and fraction.
	logic [PW-1:0] bias;
	logic          neg;
	logic [PW-1:0] ydiff;
	logic [QW-1:0] yq;
	logic [LF-1:0] gfrac;
	logic [SW-1:0] emag;
	logic [SW-1:0] eval;

	assign bias  = (PW'(cfg.n) * PW'(RATE_FRAC_BITS)) << LF;
	assign neg   = mul_p_s1 < bias;
	assign ydiff = neg ? (bias - mul_p_s1) : (mul_p_s1 - bias);
	assign yq    = ydiff[PW-1:EXPO_FRAC_BITS];
	assign gfrac = yq[LF-1:0];
	assign emag  = SW'(yq[QW-1:LF]);
	assign eval  = neg ? (SW'(0) - emag - SW'(gfrac != '0)) : emag;

	logic          prp_v_s2;
	logic [SW-1:0] prp_s_s2;
	logic [LF-1:0] prp_f_s2;
	tag_t          prp_t_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) prp_v_s2 <= 1'b0;
		else if (adv) prp_v_s2 <= mul_v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prp_s_s2 <= eval - SW'(MANT_BITS);
			prp_f_s2 <= neg ? (LF'(0) - gfrac) : gfrac;
			prp_t_s2 <= mul_t_s1;
		end
	end

	// exp2 chain: one conditional factor per stage
	logic               ex_v_s [1:LF];
	logic [MANT_BITS:0] ex_m_s [1:LF];
	logic [LF-1:0]      ex_f_s [1:LF];
	logic [SW-1:0]      ex_s_s [1:LF];
	tag_t               ex_t_s [1:LF];
	logic               ex_cv  [0:LF-1];
	logic [MANT_BITS:0] ex_cm  [0:LF-1];
	logic [LF-1:0]      ex_cf  [0:LF-1];
	logic [SW-1:0]      ex_cs  [0:LF-1];
	tag_t               ex_ct  [0:LF-1];
	logic [MANT_BITS:0] ex_nm  [0:LF-1];

	always_comb begin
		ex_cv[0] = prp_v_s2;
		ex_cm[0] = (MANT_BITS+1)'(1) << MANT_BITS;
		ex_cf[0] = prp_f_s2;
		ex_cs[0] = prp_s_s2;
		ex_ct[0] = prp_t_s2;
		for (int i = 1; i < LF; i++) begin
			ex_cv[i] = ex_v_s[i];
			ex_cm[i] = ex_m_s[i];
			ex_cf[i] = ex_f_s[i];
			ex_cs[i] = ex_s_s[i];
			ex_ct[i] = ex_t_s[i];
		end
	end

	always_comb begin
		logic [2*MANT_BITS+1:0] pr;
		for (int i = 0; i < LF; i++) begin
			pr = (2*MANT_BITS+2)'(ex_cm[i]) * (2*MANT_BITS+2)'(EXP_C[i]);
			ex_nm[i] = ex_cf[i][LF-1-i] ? pr[2*MANT_BITS:MANT_BITS] : ex_cm[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LF; i++) ex_v_s[i] <= 1'b0;
		end else if (adv) begin
			for (int i = 0; i < LF; i++) ex_v_s[i+1] <= ex_cv[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < LF; i++) begin
				ex_m_s[i+1] <= ex_nm[i];
				ex_f_s[i+1] <= ex_cf[i];
				ex_s_s[i+1] <= ex_cs[i];
				ex_t_s[i+1] <= ex_ct[i];
			end
		end
	end

	// k times the mantissa, as two half-width partial products
	logic                    pp_v_s3;
	logic [HW+MANT_BITS:0]   pp_hi_s3;
	logic [HW+MANT_BITS:0]   pp_lo_s3;
	logic [SW-1:0]           pp_s_s3;
	tag_t                    pp_t_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pp_v_s3 <= 1'b0;
		else if (adv) pp_v_s3 <= ex_v_s[LF];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pp_hi_s3 <= (HW+MANT_BITS+1)'(cfg.k[VALUE_W-1:HW]) * (HW+MANT_BITS+1)'(ex_m_s[LF]);
			pp_lo_s3 <= (HW+MANT_BITS+1)'(cfg.k[HW-1:0]) * (HW+MANT_BITS+1)'(ex_m_s[LF]);
			pp_s_s3  <= ex_s_s[LF];
			pp_t_s3  <= ex_t_s[LF];
		end
	end

	logic           sum_v_s4;
	logic [PRW-1:0] sum_p_s4;
	logic [SW-1:0]  sum_s_s4;
	tag_t           sum_t_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sum_v_s4 <= 1'b0;
		else if (adv) sum_v_s4 <= pp_v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_p_s4 <= PRW'({pp_hi_s3, {HW{1'b0}}}) + PRW'(pp_lo_s3);
			sum_s_s4 <= pp_s_s3;
			sum_t_s4 <= pp_t_s3;
		end
	end

	// Scale by 2^s with saturation detection.
	logic [PRW+VALUE_W-1:0] lwide;
	logic [PRW-1:0]         rwide;
	logic [SW-1:0]          rsh;
	logic [VALUE_W-1:0]     kp;
	logic                   over;

	assign lwide = {{VALUE_W{1'b0}}, sum_p_s4} << sum_s_s4[5:0];
	assign rsh   = SW'(0) - sum_s_s4;
	assign rwide = sum_p_s4 >> rsh[6:0];

	always_comb begin
		kp   = '0;
		over = 1'b0;
		if (sum_t_s4.zero) begin
			kp = (cfg.n == '0) ? cfg.k : '0;
		end else if (sum_p_s4 != '0) begin
			if (!sum_s_s4[SW-1]) begin
				over = (sum_s_s4 >= SW'(VALUE_W)) || (lwide[PRW+VALUE_W-1:VALUE_W] != '0);
				kp   = lwide[VALUE_W-1:0];
			end else if (rsh < SW'(PRW)) begin
				over = (rwide[PRW-1:VALUE_W] != '0);
				kp   = rwide[VALUE_W-1:0];
			end
		end
	end

	logic       res_v_s5;
	power_res_t res_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_v_s5 <= 1'b0;
		else if (adv) res_v_s5 <= sum_v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) res_s5 <= '{over: over, kp: kp, tag: sum_t_s4};
	end

	assign out_valid = res_v_s5;
	assign out_res   = res_s5;

endmodule

// ===== hw/rtl/ysv_divide.sv =====
// Back end, second half: adds tau0, divides by the rate one quotient bit per stage, caps.
// Depends on ysv_pkg.
module ysv_divide (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  ysv_pkg::power_res_t in_res,
	input  ysv_pkg::cfg_t       cfg,
	output logic                out_valid,
	output ysv_pkg::result_t    out_res
);
	import ysv_pkg::*;

	localparam int QB = VALUE_W;

	logic [VALUE_W:0]   num;
	logic [VALUE_W-1:0] divisor;
	logic [VALUE_W-1:0] num_top;

	assign num     = {1'b0, in_res.kp} + {1'b0, cfg.tau0};
	assign divisor = in_res.tag.zero ? VALUE_W'(1) : in_res.tag.rate;
	assign num_top = VALUE_W'(num[VALUE_W-1:RATE_FRAC_BITS]);

	// The quotient reaches 2^48 exactly when the top of the numerator is not below the divisor.
	logic                      st_v_s1;
	logic                      st_over_s1;
	logic [VALUE_W-1:0]        st_d_s1;
	logic [VALUE_W-1:0]        st_rem_s1;
	logic [RATE_FRAC_BITS-1:0] st_lo_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_v_s1 <= 1'b0;
		else if (adv) st_v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_over_s1 <= in_res.over || num[VALUE_W] || (num_top >= divisor);
			st_d_s1    <= divisor;
			st_rem_s1  <= num_top;
			st_lo_s1   <= num[RATE_FRAC_BITS-1:0];
		end
	end

	logic                      dv_v_s    [1:QB];
	logic                      dv_over_s [1:QB];
	logic [VALUE_W-1:0]        dv_d_s    [1:QB];
	logic [VALUE_W-1:0]        dv_rem_s  [1:QB];
	logic [VALUE_W-1:0]        dv_q_s    [1:QB];
	logic [RATE_FRAC_BITS-1:0] dv_lo_s   [1:QB];
	logic                      cv        [0:QB-1];
	logic                      c_over    [0:QB-1];
	logic [VALUE_W-1:0]        cd        [0:QB-1];
	logic [VALUE_W-1:0]        crem      [0:QB-1];
	logic [VALUE_W-1:0]        cq        [0:QB-1];
	logic [RATE_FRAC_BITS-1:0] clo       [0:QB-1];
	logic [VALUE_W-1:0]        nrem      [0:QB-1];
	logic [VALUE_W-1:0]        nq        [0:QB-1];

	always_comb begin
		cv[0]     = st_v_s1;
		c_over[0] = st_over_s1;
		cd[0]     = st_d_s1;
		crem[0]   = st_rem_s1;
		cq[0]     = '0;
		clo[0]    = st_lo_s1;
		for (int j = 1; j < QB; j++) begin
			cv[j]     = dv_v_s[j];
			c_over[j] = dv_over_s[j];
			cd[j]     = dv_d_s[j];
			crem[j]   = dv_rem_s[j];
			cq[j]     = dv_q_s[j];
			clo[j]    = dv_lo_s[j];
		end
	end

	always_comb begin
		logic [VALUE_W:0] trial;
		logic             ge;
		for (int j = 0; j < QB; j++) begin
			trial   = {crem[j], clo[j][RATE_FRAC_BITS-1]};
			ge      = trial >= {1'b0, cd[j]};
			nrem[j] = ge ? VALUE_W'(trial - {1'b0, cd[j]}) : trial[VALUE_W-1:0];
			nq[j]   = {cq[j][VALUE_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j <= QB; j++) dv_v_s[j] <= 1'b0;
		end else if (adv) begin
			for (int j = 0; j < QB; j++) dv_v_s[j+1] <= cv[j];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < QB; j++) begin
				dv_over_s[j+1] <= c_over[j];
				dv_d_s[j+1]    <= cd[j];
				dv_rem_s[j+1]  <= nrem[j];
				dv_q_s[j+1]    <= nq[j];
				dv_lo_s[j+1]   <= {clo[j][RATE_FRAC_BITS-2:0], 1'b0};
			end
		end
	end

	logic    out_valid_q;
	result_t out_res_q;
	logic    hit_cap;

	assign hit_cap = dv_over_s[QB] || (dv_q_s[QB] > cfg.cap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= dv_v_s[QB];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_res_q.viscosity <= hit_cap ? cfg.cap : dv_q_s[QB];
			out_res_q.capped    <= hit_cap;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule

// ===== hw/rtl/yield_stress_viscosity.sv =====
// Throughput: one cell per cycle unless a result is held at the output; log2, exp2 and the
// quotient are each one step per stage. A result held at the output freezes the whole
// back-end pipeline; the four-entry queue keeps taking input until it fills.
// Reset clears the queue, all valid bits and the registers to their reset values.
// Top level of the yield-stress viscosity block; depends on ysv_pkg, ysv_if and submodules.
module yield_stress_viscosity #(
	parameter int POW_TABLE_ADDR_BITS = ysv_pkg::POW_TABLE_ADDR_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	ysv_rate_if.sink                        rate,
	ysv_visc_if.source                      visc,
	input  logic                            cfg_wr_en,
	input  logic [ysv_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ysv_pkg::VALUE_W-1:0]     cfg_wr_data
);
	import ysv_pkg::*;

	cfg_t        cfg_q;
	logic        queue_full;
	logic        push;
	front_item_t front_item;
	logic        q_valid;
	front_item_t q_item;
	logic        adv;
	logic        pw_valid;
	power_res_t  pw_res;
	logic        res_valid;
	result_t     res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.k    <= K_RESET;
			cfg_q.n    <= N_RESET;
			cfg_q.tau0 <= TAU_RESET;
			cfg_q.cap  <= CAP_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CONSISTENCY: cfg_q.k    <= cfg_wr_data;
				REG_EXPONENT:    cfg_q.n    <= cfg_wr_data[EXPO_N_W-1:0];
				REG_YIELD:       cfg_q.tau0 <= cfg_wr_data;
				REG_CAP:         cfg_q.cap  <= cfg_wr_data;
				default:         cfg_q      <= cfg_q;
			endcase
		end
	end

	// The back end moves whenever the output register is free or being emptied.
	assign adv = !res_valid || visc.ready;

	ysv_front u_front (
		.rate       (rate),
		.queue_full (queue_full),
		.push       (push),
		.item       (front_item)
	);

	ysv_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_item  (front_item),
		.full     (queue_full),
		.pop      (adv),
		.rd_valid (q_valid),
		.rd_item  (q_item)
	);

	ysv_power #(
		.POW_TABLE_ADDR_BITS (POW_TABLE_ADDR_BITS)
	) u_power (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (q_valid),
		.in_item   (q_item),
		.cfg       (cfg_q),
		.out_valid (pw_valid),
		.out_res   (pw_res)
	);

	ysv_divide u_divide (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (pw_valid),
		.in_res    (pw_res),
		.cfg       (cfg_q),
		.out_valid (res_valid),
		.out_res   (res)
	);

	assign visc.valid     = res_valid;
	assign visc.viscosity = res.viscosity;
	assign visc.capped    = res.capped;

endmodule
